// ===== hdl/rfd_pkg.sv =====
// Shared types and constants of the remote frame decoder.
// No dependencies; used by every module of the block.
package rfd_pkg;

  localparam int unsigned FRAME_LEN   = 18;
  localparam int unsigned DECODE_LEN  = 16;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned DEADBAND_W  = 6;
  localparam int unsigned LIMIT_W     = 10;
  localparam int unsigned STICK_W     = 11;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 6'd5;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 10'd660;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STICK_LIMIT = 2'd1;

  // Input word kinds.
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_IDLE = 1'b1
  } kind_t;

  // Left switch codes that drive the sticky latch.
  localparam logic [1:0] SW_HOLD = 2'd0;
  localparam logic [1:0] SW_SET  = 2'd3;

  // Bytes 0..15 of a complete frame; bytes 16 and 17 carry nothing decoded.
  typedef logic [DECODE_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/rfd_front.sv =====
// Front end: accepts input words, collects frame bytes and pushes complete frames.
// Depends on rfd_pkg.
module rfd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [7:0]                    rx_byte,
  input  rfd_pkg::q_status_t            q_status,
  output rfd_pkg::push_t                push
);

  logic [rfd_pkg::COUNT_W-1:0] byte_count;
  logic [rfd_pkg::COUNT_W-1:0] byte_count_next;
  rfd_pkg::frame_t              frame_bytes;
  logic                         accept;
  logic                         is_idle;

  // Hold input while no queue slot is free for a possible frame.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign is_idle  = (rfd_pkg::kind_t'(kind) == rfd_pkg::KIND_IDLE);

  always_comb begin
    byte_count_next = byte_count;
    if (accept) begin
      if (is_idle) begin
        byte_count_next = '0;
      end else if (byte_count < rfd_pkg::COUNT_W'(rfd_pkg::FRAME_LEN)) begin
        byte_count_next = byte_count + 1'b1;
      end else begin
        byte_count_next = rfd_pkg::COUNT_W'(rfd_pkg::FRAME_LEN + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  // Store only the decoded bytes; later ones just advance the count.
  always_ff @(posedge clk) begin
    if (accept && !is_idle && byte_count < rfd_pkg::COUNT_W'(rfd_pkg::DECODE_LEN)) begin
      frame_bytes[byte_count[3:0]] <= rx_byte;
    end
  end

  assign push.valid = accept && is_idle &&
                      (byte_count == rfd_pkg::COUNT_W'(rfd_pkg::FRAME_LEN));
  assign push.frame = frame_bytes;

endmodule

// ===== hdl/rfd_queue.sv =====
// Short frame queue between front and back end.
// Depends on rfd_pkg.
module rfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  rfd_pkg::push_t     push,
  input  logic               pop,
  output rfd_pkg::frame_t    head,
  output rfd_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rfd_pkg::frame_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.frame;
    end
  end

endmodule

// ===== hdl/rfd_back.sv =====
// Back end: decodes queued frames, keeps the sticky latch, holds the result word.
// Depends on rfd_pkg.
module rfd_back (
  input  logic                               clk,
  input  logic                               rst,
  input  rfd_pkg::frame_t                    head,
  input  rfd_pkg::q_status_t                 q_status,
  output logic                               pop,
  input  logic [rfd_pkg::DEADBAND_W-1:0]     deadband,
  input  logic [rfd_pkg::LIMIT_W-1:0]        stick_limit,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rfd_pkg::STICK_W-1:0] stick_one,
  output logic signed [rfd_pkg::STICK_W-1:0] stick_two,
  output logic signed [rfd_pkg::STICK_W-1:0] stick_three,
  output logic signed [rfd_pkg::STICK_W-1:0] stick_four,
  output logic [3:0]                         switch_bits,
  output logic                               left_latch,
  output logic signed [15:0]                 mouse_x,
  output logic signed [15:0]                 mouse_y,
  output logic signed [15:0]                 mouse_z,
  output logic [7:0]                         mouse_left,
  output logic [7:0]                         mouse_right,
  output logic [15:0]                        key_map
);

  localparam int unsigned SW = rfd_pkg::STICK_W;

  logic [SW-1:0]        raw   [4];
  logic signed [SW-1:0] stick [4];
  logic [3:0]           over;
  logic [1:0]           sw_left;
  logic [1:0]           sw_right;
  logic                 latch_flag;
  logic                 latch_next;
  logic                 zero_all;

  // Centre a raw stick (subtract 1024 = flip the top bit) and apply deadband.
  function automatic logic signed [SW-1:0] centre(input logic [SW-1:0] r,
                                                  input logic [rfd_pkg::DEADBAND_W-1:0] db);
    logic signed [SW-1:0] v;
    logic [SW-1:0]        mag;
    v   = {~r[SW-1], r[SW-2:0]};
    mag = v[SW-1] ? (~v + 1'b1) : v;
    if (mag <= SW'(db)) begin
      v = '0;
    end
    return v;
  endfunction

  function automatic logic above(input logic signed [SW-1:0] v,
                                 input logic [rfd_pkg::LIMIT_W-1:0] lim);
    logic [SW-1:0] mag;
    mag = v[SW-1] ? (~v + 1'b1) : v;
    return mag > SW'(lim);
  endfunction

  assign raw[0] = {head[1][2:0], head[0]};
  assign raw[1] = {head[2][5:0], head[1][7:3]};
  assign raw[2] = {head[4][0], head[3], head[2][7:6]};
  assign raw[3] = {head[5][3:0], head[4][7:1]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      stick[i] = centre(raw[i], deadband);
      over[i]  = above(stick[i], stick_limit);
    end
  end

  assign sw_left  = head[5][7:6];
  assign sw_right = head[5][5:4];
  assign zero_all = |over;

  always_comb begin
    if (zero_all) begin
      latch_next = 1'b0;
    end else if (sw_left == rfd_pkg::SW_SET) begin
      latch_next = 1'b1;
    end else if (sw_left != rfd_pkg::SW_HOLD) begin
      latch_next = 1'b0;
    end else begin
      latch_next = latch_flag;
    end
  end

  // Advance when a frame waits and the result register is free or being taken.
  assign pop = !q_status.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      latch_flag <= 1'b0;
    end else begin
      if (pop) begin
        out_valid  <= 1'b1;
        latch_flag <= latch_next;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (zero_all) begin
        stick_one   <= '0;
        stick_two   <= '0;
        stick_three <= '0;
        stick_four  <= '0;
        switch_bits <= '0;
        left_latch  <= 1'b0;
        mouse_x     <= '0;
        mouse_y     <= '0;
        mouse_z     <= '0;
        mouse_left  <= '0;
        mouse_right <= '0;
        key_map     <= '0;
      end else begin
        stick_one   <= stick[0];
        stick_two   <= stick[1];
        stick_three <= stick[2];
        stick_four  <= stick[3];
        switch_bits <= {sw_left, sw_right};
        left_latch  <= latch_next;
        mouse_x     <= {head[7], head[6]};
        mouse_y     <= {head[9], head[8]};
        mouse_z     <= {head[11], head[10]};
        mouse_left  <= head[12];
        mouse_right <= head[13];
        key_map     <= {head[15], head[14]};
      end
    end
  end

  // A set latch in a result can only come from a set or a held left switch.
  a_latch_switch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && left_latch) |->
      (switch_bits[3:2] == rfd_pkg::SW_SET || switch_bits[3:2] == rfd_pkg::SW_HOLD))
    else $error("latch set with a clearing left switch");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped frame did not reach the result register");

  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (latch_flag == $past(latch_flag)))
    else $error("latch moved while the result was stalled");

endmodule

// ===== hdl/remote_frame_decoder_unit.sv =====
// Top level of the remote frame decoder: config registers, front, queue, back.
// Depends on rfd_pkg, rfd_front, rfd_queue and rfd_back.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  kind, rx_byte
//   out      output     out_valid/out_stall  sticks, switches, latch, mouse, keys
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// One input word is taken every cycle unless the queue is full; a completing idle
// word queues its frame at its accepting edge, and the result register takes it once
// free; without a stalled result, the back end decodes one frame per cycle in
// one combinational pass (centre, deadband and limit compares) ahead of the
// result register. Reset (rst, synchronous) clears the byte count, queue, latch
// and result valid, and loads deadband 5 and stick limit 660. A stalled result
// holds while the queue keeps taking frames; input stalls only when the queue is full.
module remote_frame_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    kind,
  input  logic [7:0]                              rx_byte,
  input  logic                                    cfg_write,
  input  logic [rfd_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [rfd_pkg::STICK_W-1:0]      stick_one,
  output logic signed [rfd_pkg::STICK_W-1:0]      stick_two,
  output logic signed [rfd_pkg::STICK_W-1:0]      stick_three,
  output logic signed [rfd_pkg::STICK_W-1:0]      stick_four,
  output logic [3:0]                              switch_bits,
  output logic                                    left_latch,
  output logic signed [15:0]                      mouse_x,
  output logic signed [15:0]                      mouse_y,
  output logic signed [15:0]                      mouse_z,
  output logic [7:0]                              mouse_left,
  output logic [7:0]                              mouse_right,
  output logic [15:0]                             key_map
);

  logic [rfd_pkg::DEADBAND_W-1:0] deadband;
  logic [rfd_pkg::LIMIT_W-1:0]    stick_limit;
  rfd_pkg::push_t                 push;
  rfd_pkg::q_status_t             q_status;
  rfd_pkg::frame_t                head;
  logic                           pop;

  // Keep only each register's width; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband    <= rfd_pkg::DEADBAND_RESET;
      stick_limit <= rfd_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rfd_pkg::REG_DEADBAND:    deadband    <= cfg_data[rfd_pkg::DEADBAND_W-1:0];
        rfd_pkg::REG_STICK_LIMIT: stick_limit <= cfg_data[rfd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  rfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .rx_byte  (rx_byte),
    .q_status (q_status),
    .push     (push)
  );

  rfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  rfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .deadband    (deadband),
    .stick_limit (stick_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stick_one   (stick_one),
    .stick_two   (stick_two),
    .stick_three (stick_three),
    .stick_four  (stick_four),
    .switch_bits (switch_bits),
    .left_latch  (left_latch),
    .mouse_x     (mouse_x),
    .mouse_y     (mouse_y),
    .mouse_z     (mouse_z),
    .mouse_left  (mouse_left),
    .mouse_right (mouse_right),
    .key_map     (key_map)
  );

endmodule

// ===== tb/rfd_frame_checker.sv =====
// Scoreboard for remote_frame_decoder_unit: mirrors the frame decode and checks results.
// Depends on rfd_pkg; watches the input, config and result channels of the block.
module rfd_frame_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              kind,
  input  logic [7:0]                        rx_byte,
  input  logic                              cfg_write,
  input  logic [rfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [rfd_pkg::STICK_W-1:0] stick_one,
  input  logic signed [rfd_pkg::STICK_W-1:0] stick_two,
  input  logic signed [rfd_pkg::STICK_W-1:0] stick_three,
  input  logic signed [rfd_pkg::STICK_W-1:0] stick_four,
  input  logic [3:0]                        switch_bits,
  input  logic                              left_latch,
  input  logic signed [15:0]                mouse_x,
  input  logic signed [15:0]                mouse_y,
  input  logic signed [15:0]                mouse_z,
  input  logic [7:0]                        mouse_left,
  input  logic [7:0]                        mouse_right,
  input  logic [15:0]                       key_map,
  output int                                mismatch_count,
  output int                                results_due
);

  typedef struct packed {
    logic signed [rfd_pkg::STICK_W-1:0] stick_one;
    logic signed [rfd_pkg::STICK_W-1:0] stick_two;
    logic signed [rfd_pkg::STICK_W-1:0] stick_three;
    logic signed [rfd_pkg::STICK_W-1:0] stick_four;
    logic [3:0]                         switch_bits;
    logic                               left_latch;
    logic signed [15:0]                 mouse_x;
    logic signed [15:0]                 mouse_y;
    logic signed [15:0]                 mouse_z;
    logic [7:0]                         mouse_left;
    logic [7:0]                         mouse_right;
    logic [15:0]                        key_map;
  } frame_result_t;

  logic [7:0]                      frame_store [rfd_pkg::FRAME_LEN];
  logic [rfd_pkg::COUNT_W-1:0]     bytes_seen;
  logic                            latch_state;
  logic [rfd_pkg::DEADBAND_W-1:0]  deadband_cfg;
  logic [rfd_pkg::LIMIT_W-1:0]     limit_cfg;
  frame_result_t                   frame_results_due [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: result mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Decode the stored frame; advances the sticky latch as a side effect.
  function automatic frame_result_t decode_frame();
    frame_result_t res;
    logic [10:0]   raw [4];
    int            centred [4];
    int            mag;
    logic [1:0]    left_sw;
    logic [1:0]    right_sw;
    bit            over;
    raw[0] = {frame_store[1][2:0], frame_store[0]};
    raw[1] = {frame_store[2][5:0], frame_store[1][7:3]};
    raw[2] = {frame_store[4][0], frame_store[3], frame_store[2][7:6]};
    raw[3] = {frame_store[5][3:0], frame_store[4][7:1]};
    over = 1'b0;
    for (int i = 0; i < 4; i++) begin
      centred[i] = int'(raw[i]) - 1024;
      mag = (centred[i] < 0) ? -centred[i] : centred[i];
      if (mag <= int'(deadband_cfg)) begin
        centred[i] = 0;
        mag = 0;
      end
      if (mag > int'(limit_cfg)) over = 1'b1;
    end
    left_sw  = frame_store[5][7:6];
    right_sw = frame_store[5][5:4];
    if (left_sw == rfd_pkg::SW_SET) latch_state = 1'b1;
    else if (left_sw != rfd_pkg::SW_HOLD) latch_state = 1'b0;
    res = '0;
    if (over) begin
      latch_state = 1'b0;
      return res;
    end
    res.stick_one   = rfd_pkg::STICK_W'(centred[0]);
    res.stick_two   = rfd_pkg::STICK_W'(centred[1]);
    res.stick_three = rfd_pkg::STICK_W'(centred[2]);
    res.stick_four  = rfd_pkg::STICK_W'(centred[3]);
    res.switch_bits = {left_sw, right_sw};
    res.left_latch  = latch_state;
    res.mouse_x     = {frame_store[7], frame_store[6]};
    res.mouse_y     = {frame_store[9], frame_store[8]};
    res.mouse_z     = {frame_store[11], frame_store[10]};
    res.mouse_left  = frame_store[12];
    res.mouse_right = frame_store[13];
    res.key_map     = {frame_store[15], frame_store[14]};
    return res;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      bytes_seen   = '0;
      latch_state  = 1'b0;
      deadband_cfg = rfd_pkg::DEADBAND_RESET;
      limit_cfg    = rfd_pkg::LIMIT_RESET;
      frame_results_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == rfd_pkg::REG_DEADBAND)
          deadband_cfg = cfg_data[rfd_pkg::DEADBAND_W-1:0];
        else if (cfg_index == rfd_pkg::REG_STICK_LIMIT)
          limit_cfg = cfg_data[rfd_pkg::LIMIT_W-1:0];
      end
      // Results first: an expectation queued at this edge cannot leave yet.
      if (out_valid && !out_stall) begin
        if (frame_results_due.size() == 0) begin
          report_mismatch("result word with no frame pending");
        end else begin
          want = frame_results_due.pop_front();
          compare_field("stick_one", stick_one, want.stick_one);
          compare_field("stick_two", stick_two, want.stick_two);
          compare_field("stick_three", stick_three, want.stick_three);
          compare_field("stick_four", stick_four, want.stick_four);
          compare_field("switch_bits", switch_bits, want.switch_bits);
          compare_field("left_latch", left_latch, want.left_latch);
          compare_field("mouse_x", mouse_x, want.mouse_x);
          compare_field("mouse_y", mouse_y, want.mouse_y);
          compare_field("mouse_z", mouse_z, want.mouse_z);
          compare_field("mouse_left", mouse_left, want.mouse_left);
          compare_field("mouse_right", mouse_right, want.mouse_right);
          compare_field("key_map", key_map, want.key_map);
        end
      end
      if (in_valid && !in_stall) begin
        if (kind == rfd_pkg::KIND_BYTE) begin
          if (bytes_seen < rfd_pkg::FRAME_LEN) begin
            frame_store[bytes_seen] = rx_byte;
            bytes_seen++;
          end else begin
            bytes_seen = rfd_pkg::COUNT_W'(rfd_pkg::FRAME_LEN + 1);
          end
        end else begin
          if (bytes_seen == rfd_pkg::FRAME_LEN)
            frame_results_due.push_back(decode_frame());
          bytes_seen = '0;
        end
      end
    end
    results_due = frame_results_due.size();
  end

endmodule

// ===== tb/tb_remote_frame_decoder_unit.sv =====
// Testbench top for remote_frame_decoder_unit: clock, reset, stimulus and verdict.
// Depends on rfd_pkg, the block and rfd_frame_checker, which does all checking.
module tb_remote_frame_decoder_unit;

  // Settle time before a config write or the verdict; covers a queued frame.
  localparam int SETTLE = 8;

  // Left switch codes that clear the latch, and config indexes the block ignores.
  localparam logic [1:0] SW_CLEAR_LO = 2'd1;
  localparam logic [1:0] SW_CLEAR_HI = 2'd2;
  localparam logic [rfd_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [rfd_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            kind = rfd_pkg::KIND_BYTE;
  logic [7:0]                      rx_byte = 8'h00;
  logic                            cfg_write = 1'b0;
  logic [rfd_pkg::CFG_INDEX_W-1:0] cfg_index = rfd_pkg::REG_DEADBAND;
  logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [rfd_pkg::STICK_W-1:0] stick_one;
  logic signed [rfd_pkg::STICK_W-1:0] stick_two;
  logic signed [rfd_pkg::STICK_W-1:0] stick_three;
  logic signed [rfd_pkg::STICK_W-1:0] stick_four;
  logic [3:0]                      switch_bits;
  logic                            left_latch;
  logic signed [15:0]              mouse_x;
  logic signed [15:0]              mouse_y;
  logic signed [15:0]              mouse_z;
  logic [7:0]                      mouse_left;
  logic [7:0]                      mouse_right;
  logic [15:0]                     key_map;

  int mismatch_count;
  int results_due;

  // When set, neither side idles: a stretch of back-to-back traffic.
  logic calm = 1'b0;

  // Settings in force, used to aim sticks at the deadband and limit edges.
  logic [rfd_pkg::DEADBAND_W-1:0] cur_deadband = rfd_pkg::DEADBAND_RESET;
  logic [rfd_pkg::LIMIT_W-1:0]    cur_limit    = rfd_pkg::LIMIT_RESET;

  // Frame under construction; bytes past FRAME_LEN are drawn at random.
  logic [7:0] frame_buf [rfd_pkg::FRAME_LEN];

  remote_frame_decoder_unit u_top (.*);

  rfd_frame_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or a result never arrives.
  initial begin
    #4000000;
    $display("remote_frame_decoder_unit test failed");
    $finish;
  end

  // Result side: stall at random about a tenth of the time unless in a calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  // Offer one word, holding it until accepted; idle now and then first.
  task automatic send_word(input rfd_pkg::kind_t word_kind, input logic [7:0] value);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= word_kind;
    rx_byte  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send len bytes of frame_buf (random past the end), then the idle word.
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++)
      send_word(rfd_pkg::KIND_BYTE, (i < rfd_pkg::FRAME_LEN) ? frame_buf[i] : 8'($urandom));
    send_word(rfd_pkg::KIND_IDLE, 8'($urandom));
  endtask

  // Drop valid and wait until the checker holds no pending frame, then settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rfd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rfd_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Change settings only with the block drained; junk in the upper deadband
  // bits and a write to an unused index must both be ignored.
  task automatic apply_setting(input logic [rfd_pkg::DEADBAND_W-1:0] db,
                               input logic [rfd_pkg::LIMIT_W-1:0] lim);
    drain_results();
    @(posedge clk);
    write_reg(rfd_pkg::REG_DEADBAND, {4'($urandom), db});
    write_reg(rfd_pkg::REG_STICK_LIMIT, lim);
    if ($urandom_range(1) == 1)
      write_reg(($urandom_range(1) == 1) ? REG_SPARE_LO : REG_SPARE_HI, 10'($urandom));
    cfg_write <= 1'b0;
    cur_deadband = db;
    cur_limit    = lim;
  endtask

  function automatic logic [10:0] raw_of(input int centred);
    return 11'(centred + 1024);
  endfunction

  // Pack four raw 11-bit sticks and both switches into bytes 0..5.
  function automatic void place_sticks(input logic [43:0] raws, input logic [1:0] left_sw,
                                       input logic [1:0] right_sw);
    logic [10:0] r0, r1, r2, r3;
    r0 = raws[10:0];
    r1 = raws[21:11];
    r2 = raws[32:22];
    r3 = raws[43:33];
    frame_buf[0] = r0[7:0];
    frame_buf[1] = {r1[4:0], r0[10:8]};
    frame_buf[2] = {r2[1:0], r1[10:5]};
    frame_buf[3] = r2[9:2];
    frame_buf[4] = {r3[6:0], r2[10]};
    frame_buf[5] = {left_sw, right_sw, r3[10:7]};
  endfunction

  // Fill mouse, key and trailing bytes with one value or with noise.
  function automatic void fill_tail(input bit scramble, input logic [7:0] val);
    for (int i = 6; i < rfd_pkg::FRAME_LEN; i++) frame_buf[i] = scramble ? 8'($urandom) : val;
  endfunction

  task automatic directed_frame(input int v0, input int v1, input int v2, input int v3,
                                input logic [1:0] left_sw, input logic [1:0] right_sw,
                                input logic [7:0] tail);
    place_sticks({raw_of(v3), raw_of(v2), raw_of(v1), raw_of(v0)}, left_sw, right_sw);
    fill_tail(1'b0, tail);
    send_frame(rfd_pkg::FRAME_LEN);
  endtask

  // Aim a stick at the deadband edge, the limit edge, inside the limit,
  // or anywhere in the raw range.
  function automatic logic [10:0] pick_stick();
    int v;
    case ($urandom_range(19))
      0, 1, 2: return 11'($urandom);
      3, 4:    v = int'(cur_deadband) + int'($urandom_range(2)) - 1;
      5, 6:    v = int'(cur_limit) + int'($urandom_range(2)) - 1;
      default: v = int'($urandom_range(cur_limit));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    if ($urandom_range(1) == 1) v = -v;
    return raw_of(v);
  endfunction

  initial begin
    int sel;
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (deadband 5, limit 660).
    send_word(rfd_pkg::KIND_IDLE, 8'hFF);                          // idle, empty frame
    directed_frame(0, 0, 0, 0, rfd_pkg::SW_SET, 2'd3, 8'hFF);      // centred, latch set
    directed_frame(5, -5, 6, -6, rfd_pkg::SW_HOLD, 2'd0, 8'h00);   // deadband edge, held
    directed_frame(660, -660, 1, -1, SW_CLEAR_LO, 2'd1, 8'h80);    // limit edge, cleared
    directed_frame(0, 0, 0, 0, rfd_pkg::SW_SET, 2'd2, 8'h7F);
    directed_frame(661, 0, 0, 0, rfd_pkg::SW_HOLD, 2'd0, 8'h01);   // over the limit: zero
    directed_frame(0, 0, 0, -1024, rfd_pkg::SW_SET, 2'd0, 8'hAA);  // raw zero over limit
    directed_frame(7, -8, 9, -10, rfd_pkg::SW_HOLD, 2'd1, 8'h55);  // latch stays low
    directed_frame(0, 0, 0, 0, rfd_pkg::SW_SET, 2'd0, 8'h33);
    directed_frame(0, 0, 0, 0, SW_CLEAR_HI, 2'd3, 8'hCC);
    send_frame(5);                                                 // short frame
    send_frame(rfd_pkg::FRAME_LEN + 2);                            // overlong frame
    send_frame(rfd_pkg::FRAME_LEN - 1);
    send_frame(rfd_pkg::FRAME_LEN);                                // decoding recovers

    // Widest window: a stick at -1024 still exceeds the limit and zeroes the result.
    apply_setting(6'd0, 10'd1023);
    directed_frame(-1024, 1023, -1, 1, rfd_pkg::SW_SET, 2'd3, 8'hFF);
    // Limit zero with the widest deadband: only dead sticks survive.
    apply_setting(6'd63, 10'd0);
    directed_frame(63, -63, 0, 64, rfd_pkg::SW_HOLD, 2'd2, 8'h0F);
    directed_frame(63, -63, 0, -1, rfd_pkg::SW_HOLD, 2'd1, 8'hF0);

    // Random part: mostly complete frames, some short, overlong or stray idles.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       apply_setting(rfd_pkg::DEADBAND_RESET, rfd_pkg::LIMIT_RESET);
        1:       apply_setting(6'd63, 10'd1023);
        2:       apply_setting(6'd0, 10'd0);
        3:       apply_setting(6'd0, 10'd1023);
        default: apply_setting(6'($urandom), 10'($urandom_range(1023, 300)));
      endcase
      calm <= (phase == 3);
      for (int unit = 0; unit < 9; unit++) begin
        sel = $urandom_range(99);
        if (sel < 75) len = rfd_pkg::FRAME_LEN;
        else if (sel < 85) len = $urandom_range(rfd_pkg::FRAME_LEN - 1);
        else if (sel < 95)
          len = $urandom_range(rfd_pkg::FRAME_LEN + 12, rfd_pkg::FRAME_LEN + 1);
        else len = 0;
        place_sticks({pick_stick(), pick_stick(), pick_stick(), pick_stick()},
                     2'($urandom), 2'($urandom));
        fill_tail(1'b1, 8'h00);
        send_frame(len);
      end
    end
    calm <= 1'b0;

    // Let every result out, then give the verdict.
    drain_results();
    if (mismatch_count == 0) begin
      $display("remote_frame_decoder_unit test passed");
    end else begin
      $display("remote_frame_decoder_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rfd_pkg.sv
hdl/rfd_front.sv
hdl/rfd_queue.sv
hdl/rfd_back.sv
hdl/remote_frame_decoder_unit.sv
tb/rfd_frame_checker.sv
tb/tb_remote_frame_decoder_unit.sv
